>>> design/vlrc_pkg.sv
// Shared types and constants for the versioned LRU result cache.
package vlrc_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int NUM_COLL = 256;
	localparam int COLL_W   = $clog2(NUM_COLL);
	localparam int VER_W    = 32;
	localparam int RANK_W   = IDX_W;

	localparam logic [1:0] ACT_GET    = 2'd0;
	localparam logic [1:0] ACT_PUT    = 2'd1;
	localparam logic [1:0] ACT_INVAL  = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [2:0] ST_MISS     = 3'd0;
	localparam logic [2:0] ST_HIT      = 3'd1;
	localparam logic [2:0] ST_INSERTED = 3'd2;
	localparam logic [2:0] ST_UPDATED  = 3'd3;
	localparam logic [2:0] ST_EVICTED  = 3'd4;
	localparam logic [2:0] ST_INVALID  = 3'd5;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] key_collection;
		logic [63:0] vector_hash;
		logic [31:0] top_k;
		logic [63:0] filter_hash;
		logic [7:0]  version_collection;
		logic [63:0] result_value;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        stale_dropped;
		logic [63:0] hit_result;
		logic [4:0]  entry_count;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
		logic [31:0] eviction_count;
	} rsp_t;

	typedef struct packed {
		logic [31:0] key_collection;
		logic [63:0] vector_hash;
		logic [31:0] top_k;
		logic [63:0] filter_hash;
	} key_t;

	typedef struct packed {
		key_t              key;
		logic [63:0]       result;
		logic [VER_W-1:0]  version;
		logic [RANK_W-1:0] rank;
	} entry_t;

endpackage

>>> design/vlrc_ram.sv
// Generic simple dual-port RAM with registered read.
module vlrc_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/versioned_lru_result_cache_unit.sv
// Top level of the versioned LRU result cache: sequencer around entry and version RAMs.
//
// Usage: present a request on req and raise start while busy is low; the request is
// taken at that clock edge. One result per request appears on rsp, marked by done
// for exactly one cycle; the receiver cannot stall it and must take it then.
// A hit, a stale drop or an update runs a 16-entry key scan, a decide step and a
// 16-entry rank update sweep; a put of a new key adds an insert write after the
// sweep. A get miss, an invalidate or an unknown action ends after the scan and the
// decide step.
// Both passes go one entry per cycle through the single read port of the entry RAM.
// busy stays high until done; a new request may start in the done cycle.
// The entry limit is written through cfg_we/cfg_wdata; the user must do so while idle
// (not enforced by the block). Values 0 and above 16 act as 1 and 16.
// Reset clears all entry valid bits, all collection versions (by valid flags in
// flip-flops), the counters and the fill, and sets the entry limit to 16. No clearing
// pass is needed; the block is ready in the first cycle after reset.
module versioned_lru_result_cache_unit
	import vlrc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       req,
	output logic       done,
	output rsp_t       rsp,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SWEEP  = 3'd3;
	localparam logic [2:0] S_INS    = 3'd4;

	localparam logic [1:0] M_RECENT = 2'd0;
	localparam logic [1:0] M_DROP   = 2'd1;
	localparam logic [1:0] M_INSERT = 2'd2;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	logic [2:0]          state_q;
	logic [IDX_W-1:0]    cnt_q;
	req_t                req_q;
	logic [4:0]          max_q;
	logic [CAPACITY-1:0] valid_q;
	logic [NUM_COLL-1:0] cv_valid_q;
	logic [CNT_W-1:0]    fill_q;
	logic [31:0]         hits_q, misses_q, evicts_q;
	logic [VER_W-1:0]    cur_q;
	logic                found_q;
	logic [IDX_W-1:0]    match_idx_q;
	logic [RANK_W-1:0]   match_rank_q;
	logic [VER_W-1:0]    match_ver_q;
	logic [63:0]         match_res_q;
	logic [1:0]          mode_q;
	logic                upd_q;
	logic                evict_q;
	logic [RANK_W-1:0]   thr_q;
	logic [2:0]          status_q;
	logic                stale_q;
	logic [63:0]         hres_q;
	logic                done_q;

	logic              ent_we, ent_re;
	logic [IDX_W-1:0]  ent_waddr, ent_raddr;
	entry_t            ent_wdata, ent_rdata;
	logic              cv_we, cv_re;
	logic [COLL_W-1:0] cv_waddr, cv_raddr;
	logic [VER_W-1:0]  cv_wdata, cv_rdata;

	logic              accept;
	key_t              req_key;
	logic              key_eq;
	logic [CNT_W-1:0]  lim;
	logic [IDX_W-1:0]  free_idx;
	entry_t            sweep_word;
	logic              sweep_drop;

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign req_key = '{req_q.key_collection, req_q.vector_hash, req_q.top_k,
		req_q.filter_hash};
	assign key_eq  = (ent_rdata.key == req_key);

	always_comb begin
		if (max_q == 5'd0) begin
			lim = CNT_W'(1);
		end else if (max_q > 5'(CAPACITY)) begin
			lim = CNT_W'(CAPACITY);
		end else begin
			lim = CNT_W'(max_q);
		end
	end

	always_comb begin
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	// rank rewrite for the entry whose data is on the read port
	always_comb begin
		sweep_word = ent_rdata;
		sweep_drop = 1'b0;
		case (mode_q)
			M_RECENT: begin
				if (cnt_q == match_idx_q) begin
					sweep_word.rank = '0;
					if (upd_q) begin
						sweep_word.result = req_q.result_value;
					end
				end else if (ent_rdata.rank < match_rank_q) begin
					sweep_word.rank = ent_rdata.rank + 1'b1;
				end
			end
			M_DROP: begin
				if (ent_rdata.rank > match_rank_q) begin
					sweep_word.rank = ent_rdata.rank - 1'b1;
				end
			end
			M_INSERT: begin
				if (evict_q && ent_rdata.rank >= thr_q) begin
					sweep_drop = 1'b1;
				end else begin
					sweep_word.rank = ent_rdata.rank + 1'b1;
				end
			end
			default: begin
				sweep_word = ent_rdata;
			end
		endcase
	end

	always_comb begin
		ent_re    = 1'b0;
		ent_raddr = cnt_q + 1'b1;
		ent_we    = 1'b0;
		ent_waddr = cnt_q;
		ent_wdata = sweep_word;
		if (accept || state_q == S_DECIDE) begin
			ent_re    = 1'b1;
			ent_raddr = '0;
		end else if ((state_q == S_SCAN || state_q == S_SWEEP) && cnt_q != LAST_IDX) begin
			ent_re = 1'b1;
		end
		if (state_q == S_SWEEP && valid_q[cnt_q] && !sweep_drop) begin
			ent_we = 1'b1;
		end else if (state_q == S_INS) begin
			ent_we    = 1'b1;
			ent_waddr = free_idx;
			ent_wdata = '{req_key, req_q.result_value, cur_q, RANK_W'(0)};
		end
	end

	assign cv_re    = accept;
	assign cv_raddr = req.version_collection;
	assign cv_we    = (state_q == S_DECIDE) && (req_q.action == ACT_INVAL);
	assign cv_waddr = req_q.version_collection;
	assign cv_wdata = cur_q + 1'b1;

	vlrc_ram #(.W($bits(entry_t)), .D(CAPACITY)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	vlrc_ram #(.W(VER_W), .D(NUM_COLL)) u_version_ram (
		.clk   (clk),
		.we    (cv_we),
		.waddr (cv_waddr),
		.wdata (cv_wdata),
		.re    (cv_re),
		.raddr (cv_raddr),
		.rdata (cv_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			max_q      <= 5'(CAPACITY);
			valid_q    <= '0;
			cv_valid_q <= '0;
			fill_q     <= '0;
			hits_q     <= '0;
			misses_q   <= '0;
			evicts_q   <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					cnt_q   <= '0;
					state_q <= S_SWEEP;
					case (req_q.action)
						ACT_GET: begin
							if (!found_q) begin
								misses_q <= misses_q + 1'b1;
								state_q  <= S_IDLE;
								done_q   <= 1'b1;
							end else if (match_ver_q != cur_q) begin
								valid_q[match_idx_q] <= 1'b0;
								fill_q   <= fill_q - 1'b1;
								misses_q <= misses_q + 1'b1;
							end else begin
								hits_q <= hits_q + 1'b1;
							end
						end
						ACT_PUT: begin
						end
						ACT_INVAL: begin
							cv_valid_q[req_q.version_collection] <= 1'b1;
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
						default: begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					endcase
				end
				S_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (valid_q[cnt_q] && sweep_drop) begin
						valid_q[cnt_q] <= 1'b0;
						fill_q   <= fill_q - 1'b1;
						evicts_q <= evicts_q + 1'b1;
					end
					if (cnt_q == LAST_IDX) begin
						if (mode_q == M_INSERT) begin
							state_q <= S_INS;
						end else begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				S_INS: begin
					valid_q[free_idx] <= 1'b1;
					fill_q  <= fill_q + 1'b1;
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request data path, scan tracking and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req;
			found_q <= 1'b0;
		end
		if (state_q == S_SCAN) begin
			if (cnt_q == '0) begin
				cur_q <= cv_valid_q[req_q.version_collection] ? cv_rdata : '0;
			end
			if (valid_q[cnt_q] && key_eq && !found_q) begin
				found_q      <= 1'b1;
				match_idx_q  <= cnt_q;
				match_rank_q <= ent_rdata.rank;
				match_ver_q  <= ent_rdata.version;
				match_res_q  <= ent_rdata.result;
			end
		end
		if (state_q == S_DECIDE) begin
			status_q <= ST_MISS;
			stale_q  <= 1'b0;
			hres_q   <= '0;
			mode_q   <= M_RECENT;
			upd_q    <= 1'b0;
			evict_q  <= 1'b0;
			thr_q    <= RANK_W'(lim - 1'b1);
			case (req_q.action)
				ACT_GET: begin
					if (found_q && match_ver_q != cur_q) begin
						mode_q  <= M_DROP;
						stale_q <= 1'b1;
					end else if (found_q) begin
						status_q <= ST_HIT;
						hres_q   <= match_res_q;
					end
				end
				ACT_PUT: begin
					if (found_q) begin
						upd_q    <= 1'b1;
						status_q <= ST_UPDATED;
					end else begin
						mode_q   <= M_INSERT;
						evict_q  <= (fill_q >= lim);
						status_q <= (fill_q >= lim) ? ST_EVICTED : ST_INSERTED;
					end
				end
				ACT_INVAL: begin
					status_q <= ST_INVALID;
				end
				default: begin
					status_q <= ST_MISS;
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = '{status_q, stale_q, hres_q, 5'(fill_q), hits_q, misses_q, evicts_q};

	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill above capacity");

	a_fill_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> $countones(valid_q) == 32'(fill_q))
		else $error("fill does not match valid entries");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobe while busy");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |=> state_q == S_SCAN || state_q == S_DECIDE)
		else $error("scan left early");

endmodule
